@@ rtl/dss_pkg.sv @@
// shared types and constants for the two-stack shared-array core
// no dependencies

package dss_pkg;

	localparam int DEPTH_DEF = 256;
	localparam int DATA_W    = 32;
	localparam int CAP_W     = 9;
	localparam int IN_TDATA_W  = 32;
	localparam int IN_TUSER_W  = 4;
	localparam int OUT_TDATA_W = 56;

	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_POP   = 2'd1,
		CMD_PEEK  = 2'd2,
		CMD_CLEAR = 2'd3
	} command_t;

	localparam logic [1:0] SEL_A = 2'd0;
	localparam logic [1:0] SEL_B = 2'd1;

	typedef struct packed {
		logic             ok;
		logic             peek_ok;
		logic [CAP_W-1:0] count_a;
		logic [CAP_W-1:0] count_b;
		logic             full;
	} result_meta_t;

endpackage

@@ rtl/dual_stack_shared_array_core.sv @@
// two stacks in one array: one command beat accepted per cycle while s_axis_tready is high; the result
// beat of an accepted command passes the memory read register, then the output register
// throughput one beat per cycle while the result side takes beats
// reset empties both stacks, sets capacity to DEPTH and drops all valids;
// memory contents stay undefined, no clearing pass
// depends on dss_pkg, dss_ctrl, dss_mem, dss_out

module dual_stack_shared_array_core
	import dss_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // push_data
	input  logic [IN_TUSER_W-1:0]  s_axis_tuser,  // command, stack_sel
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // ok, read_data, count_a, count_b, full_res
	input  logic                   cfg_wr_en,
	input  logic [CAP_W-1:0]       cfg_wr_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic              accept;
	logic              mem_we;
	logic              mem_re;
	logic [AW-1:0]     mem_addr;
	logic [DATA_W-1:0] mem_rdata;
	result_meta_t      meta;

	assign accept = s_axis_tvalid & s_axis_tready;

	dss_ctrl #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.command    (s_axis_tuser[1:0]),
		.stack_sel  (s_axis_tuser[3:2]),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.mem_we     (mem_we),
		.mem_re     (mem_re),
		.mem_addr   (mem_addr),
		.meta       (meta)
	);

	dss_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.re   (mem_re),
		.addr (mem_addr),
		.wdata(s_axis_tdata[DATA_W-1:0]),
		.rdata(mem_rdata)
	);

	dss_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.meta     (meta),
		.rdata    (mem_rdata),
		.in_ready (s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (m_axis_tdata)
	);

endmodule

@@ rtl/dss_mem.sv @@
// word memory shared by both stacks, one port, registered read
// depends on dss_pkg

module dss_mem
	import dss_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW    = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [AW-1:0]     addr,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[addr];
		end
	end

	assign rdata = rd_q;

endmodule

@@ rtl/dss_ctrl.sv @@
// stack pointers, capacity register and command decode
// depends on dss_pkg

module dss_ctrl
	import dss_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW    = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [1:0]        command,
	input  logic [1:0]        stack_sel,
	input  logic              cfg_wr_en,
	input  logic [CAP_W-1:0]  cfg_wr_data,
	output logic              mem_we,
	output logic              mem_re,
	output logic [AW-1:0]     mem_addr,
	output result_meta_t      meta
);

	localparam int DCAP = (DEPTH > 511) ? 511 : DEPTH;
	localparam logic [CAP_W-1:0] DEPTH_CAP = CAP_W'(DCAP);
	localparam int IW = (AW > CAP_W) ? AW : CAP_W;

	logic [CAP_W-1:0] capacity_q;
	logic [CAP_W-1:0] depth_a_q;
	logic [CAP_W-1:0] depth_b_q;

	logic [CAP_W-1:0] eff_cap;
	logic             full_pre;
	logic [CAP_W-1:0] next_a;
	logic [CAP_W-1:0] next_b;
	logic [CAP_W-1:0] idx;
	logic [IW-1:0]    idx_ext;
	logic             ok;
	logic             peek_ok;
	logic             wr;
	logic             rd;

	assign eff_cap  = (capacity_q > DEPTH_CAP) ? DEPTH_CAP : capacity_q;
	assign full_pre = ({1'b0, depth_a_q} + {1'b0, depth_b_q}) >= {1'b0, eff_cap};

	always_comb begin
		next_a  = depth_a_q;
		next_b  = depth_b_q;
		idx     = '0;
		ok      = 1'b0;
		peek_ok = 1'b0;
		wr      = 1'b0;
		rd      = 1'b0;
		unique case (command_t'(command))
			CMD_PUSH: begin
				if (stack_sel == SEL_A && !full_pre) begin
					idx    = depth_a_q;
					next_a = depth_a_q + 1'b1;
					ok     = 1'b1;
					wr     = 1'b1;
				end else if (stack_sel == SEL_B && !full_pre) begin
					idx    = eff_cap - 1'b1 - depth_b_q;
					next_b = depth_b_q + 1'b1;
					ok     = 1'b1;
					wr     = 1'b1;
				end
			end
			CMD_POP: begin
				if (stack_sel == SEL_A && depth_a_q != '0) begin
					next_a = depth_a_q - 1'b1;
					ok     = 1'b1;
				end else if (stack_sel == SEL_B && depth_b_q != '0) begin
					next_b = depth_b_q - 1'b1;
					ok     = 1'b1;
				end
			end
			CMD_PEEK: begin
				if (stack_sel == SEL_A && depth_a_q != '0) begin
					idx     = depth_a_q - 1'b1;
					ok      = 1'b1;
					peek_ok = 1'b1;
					rd      = 1'b1;
				end else if (stack_sel == SEL_B && depth_b_q != '0
						&& depth_b_q <= eff_cap) begin
					idx     = eff_cap - depth_b_q;
					ok      = 1'b1;
					peek_ok = 1'b1;
					rd      = 1'b1;
				end
			end
			CMD_CLEAR: begin
				ok = 1'b1;
				case (stack_sel)
					SEL_A:   next_a = '0;
					SEL_B:   next_b = '0;
					default: begin
						next_a = '0;
						next_b = '0;
					end
				endcase
			end
			default: ;
		endcase
	end

	assign idx_ext  = IW'(idx);
	assign mem_addr = idx_ext[AW-1:0];
	assign mem_we   = accept & wr;
	assign mem_re   = accept & rd;

	assign meta.ok      = ok;
	assign meta.peek_ok = peek_ok;
	assign meta.count_a = next_a;
	assign meta.count_b = next_b;
	assign meta.full    = ({1'b0, next_a} + {1'b0, next_b}) >= {1'b0, eff_cap};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_W'(DEPTH);
			depth_a_q  <= '0;
			depth_b_q  <= '0;
		end else if (cfg_wr_en) begin
			capacity_q <= cfg_wr_data;
			depth_a_q  <= '0;
			depth_b_q  <= '0;
		end else if (accept) begin
			depth_a_q <= next_a;
			depth_b_q <= next_b;
		end
	end

`ifndef NO_ASSERTIONS
	a_occupancy_bound: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, depth_a_q} + {1'b0, depth_b_q}) <= {1'b0, eff_cap})
		else $error("stack occupancy above capacity");

	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |=> (depth_a_q == '0 && depth_b_q == '0))
		else $error("capacity write did not empty stacks");

	a_full_push_fails: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && command == CMD_PUSH && full_pre) |-> (!meta.ok && !mem_we))
		else $error("push accepted on full array");

	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("read and write in one cycle");
`endif

endmodule

@@ rtl/dss_out.sv @@
// result stage and output register with backpressure
// depends on dss_pkg

module dss_out
	import dss_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  result_meta_t           meta,
	input  logic [DATA_W-1:0]      rdata,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_TDATA_W-1:0] out_data
);

	logic                   valid_s1;
	result_meta_t           meta_s1;
	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic                   adv;
	logic [DATA_W-1:0]      rd_word;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || adv;
	assign rd_word  = meta_s1.peek_ok ? rdata : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= load;
			end
			if (adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			meta_s1 <= meta;
		end
		if (adv && valid_s1) begin
			out_data_q <= {4'b0, meta_s1.full, meta_s1.count_b, meta_s1.count_a,
				rd_word, meta_s1.ok};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

@@ dv/dual_stack_shared_array_core_tb.sv @@
// self-checking testbench for dual_stack_shared_array_core: directed and random command beats,
// each result beat checked against a predictor of both stacks and the capacity register
// depends on dss_pkg and the core rtl
`timescale 1ns / 100ps

module dual_stack_shared_array_core_tb;
	import dss_pkg::*;

	localparam logic [1:0] SEL_BOTH     = 2'd2;
	localparam logic [1:0] SEL_BOTH_ALT = 2'd3;
	localparam int         STALL_LIMIT  = 2000;

	typedef struct packed {
		logic              ok;
		logic [DATA_W-1:0] read_data;
		logic [CAP_W-1:0]  count_a;
		logic [CAP_W-1:0]  count_b;
		logic              full;
	} stack_result_t;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // push_data
	logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;  // command, stack_sel
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;        // ok, read_data, count_a, count_b, full_res
	logic                   cfg_wr_en     = 1'b0;
	logic [CAP_W-1:0]       cfg_wr_data   = '0;

	// predictor state
	logic [DATA_W-1:0] word_mem [DEPTH_DEF];
	int unsigned       capacity_words;
	int unsigned       level_a;
	int unsigned       level_b;
	stack_result_t     results_due [$];

	bit idle_on = 1'b1;
	int ready_hold = 0;
	int idle_cycles = 0;
	int mismatches = 0;
	int beats_sent = 0;
	int beats_checked = 0;
	int full_seen = 0;
	int rejected_seen = 0;
	int capacity_writes = 0;

	dual_stack_shared_array_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	always #5 clk = ~clk;

	task automatic predict_stack_step(input command_t cmd, input logic [1:0] sel,
			input logic [DATA_W-1:0] data, output stack_result_t r);
		int unsigned eff;
		int unsigned pos;
		eff = (capacity_words > DEPTH_DEF) ? DEPTH_DEF : capacity_words;
		r = '0;
		case (cmd)
			CMD_PUSH: begin
				if (sel <= SEL_B && (level_a + level_b) < eff) begin
					if (sel == SEL_A) begin
						pos = level_a;
						level_a++;
					end else begin
						pos = eff - 1 - level_b;
						level_b++;
					end
					word_mem[pos] = data;
					r.ok = 1'b1;
				end
			end
			CMD_POP: begin
				if (sel == SEL_A && level_a > 0) begin
					level_a--;
					r.ok = 1'b1;
				end else if (sel == SEL_B && level_b > 0) begin
					level_b--;
					r.ok = 1'b1;
				end
			end
			CMD_PEEK: begin
				if (sel == SEL_A && level_a > 0) begin
					r.read_data = word_mem[level_a - 1];
					r.ok = 1'b1;
				end else if (sel == SEL_B && level_b > 0 && level_b <= eff) begin
					r.read_data = word_mem[eff - level_b];
					r.ok = 1'b1;
				end
			end
			default: begin
				if (sel == SEL_A) begin
					level_a = 0;
				end else if (sel == SEL_B) begin
					level_b = 0;
				end else begin
					level_a = 0;
					level_b = 0;
				end
				r.ok = 1'b1;
			end
		endcase
		r.count_a = level_a[CAP_W-1:0];
		r.count_b = level_b[CAP_W-1:0];
		r.full    = (level_a + level_b) >= eff;
	endtask

	task automatic send_command(input command_t cmd, input logic [1:0] sel,
			input logic [DATA_W-1:0] data);
		stack_result_t r;
		if (idle_on && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= {sel, cmd};
		s_axis_tdata  <= data;
		do @(posedge clk); while (!s_axis_tready);
		predict_stack_step(cmd, sel, data, r);
		results_due.push_back(r);
		beats_sent++;
	endtask

	task automatic wait_results_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (results_due.size() != 0) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [CAP_W-1:0] value);
		wait_results_drained();
		repeat (3) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		capacity_words = 32'(value);
		level_a = 0;
		level_b = 0;
		capacity_writes++;
	endtask

	function automatic logic [DATA_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [1:0] pick_sel();
		if ($urandom_range(0, 9) != 0)
			return 2'($urandom_range(0, 1));
		return 2'($urandom_range(2, 3));
	endfunction

	task automatic run_mixed_phase(input int beats, input int push_pct);
		int r;
		command_t cmd;
		for (int i = 0; i < beats; i++) begin
			r = $urandom_range(0, 99);
			if (r < push_pct)
				cmd = CMD_PUSH;
			else if (r < push_pct + (100 - push_pct) * 45 / 100)
				cmd = CMD_POP;
			else if (r < push_pct + (100 - push_pct) * 90 / 100)
				cmd = CMD_PEEK;
			else
				cmd = CMD_CLEAR;
			send_command(cmd, pick_sel(), pick_word());
			if ($urandom_range(0, 99) == 0)
				wait_results_drained();
		end
	endtask

	task automatic test_basic_ops();
		send_command(CMD_POP, SEL_A, '0);
		send_command(CMD_POP, SEL_B, '0);
		send_command(CMD_PEEK, SEL_A, '0);
		send_command(CMD_PEEK, SEL_B, '0);
		send_command(CMD_PUSH, SEL_A, 32'hFFFF_FFFF);
		send_command(CMD_PUSH, SEL_B, 32'h0000_0000);
		send_command(CMD_PUSH, SEL_A, 32'hA5A5_5A5A);
		send_command(CMD_PEEK, SEL_A, '0);
		send_command(CMD_PEEK, SEL_B, '0);
		send_command(CMD_PUSH, SEL_BOTH, 32'h1234_5678);
		send_command(CMD_PUSH, SEL_BOTH_ALT, 32'h8765_4321);
		send_command(CMD_POP, SEL_BOTH, '0);
		send_command(CMD_PEEK, SEL_BOTH_ALT, '0);
		send_command(CMD_POP, SEL_A, '0);
		send_command(CMD_PEEK, SEL_A, '0);
		send_command(CMD_CLEAR, SEL_B, '0);
		send_command(CMD_CLEAR, SEL_BOTH_ALT, '0);
		send_command(CMD_PUSH, SEL_B, 32'h5A5A_A5A5);
		send_command(CMD_CLEAR, SEL_BOTH, '0);
		send_command(CMD_CLEAR, SEL_A, '0);
	endtask

	task automatic test_capacity_edges();
		// zero capacity: empty and full together
		set_capacity(9'd0);
		send_command(CMD_PUSH, SEL_A, pick_word());
		send_command(CMD_PUSH, SEL_B, pick_word());
		send_command(CMD_PEEK, SEL_A, '0);
		send_command(CMD_CLEAR, SEL_A, '0);
		set_capacity(9'd1);
		send_command(CMD_PUSH, SEL_B, 32'hC0DE_F00D);
		send_command(CMD_PUSH, SEL_A, pick_word());
		send_command(CMD_PEEK, SEL_B, '0);
		send_command(CMD_POP, SEL_B, '0);
		send_command(CMD_PUSH, SEL_A, 32'h0BAD_CAFE);
		send_command(CMD_PEEK, SEL_A, '0);
		// above the array size the core clamps to DEPTH
		set_capacity(9'd511);
		send_command(CMD_PUSH, SEL_B, 32'hFEED_BEEF);
		send_command(CMD_PEEK, SEL_B, '0);
	endtask

	task automatic test_fill_full();
		set_capacity(9'(DEPTH_DEF));
		for (int i = 0; i < DEPTH_DEF; i++)
			send_command(CMD_PUSH, 2'($urandom_range(0, 1)), pick_word());
		send_command(CMD_PUSH, SEL_A, pick_word());
		send_command(CMD_PUSH, SEL_B, pick_word());
		send_command(CMD_PEEK, SEL_A, '0);
		send_command(CMD_PEEK, SEL_B, '0);
		for (int i = 0; i < 30; i++)
			send_command($urandom_range(0, 1) ? CMD_POP : CMD_PEEK,
				2'($urandom_range(0, 1)), '0);
		send_command(CMD_CLEAR, SEL_BOTH, '0);
	endtask

	task automatic test_random_mix();
		logic [CAP_W-1:0] caps [8];
		caps = '{9'd16, 9'd511, 9'd2, 9'd0, 9'd255, 9'd1, 9'd0, 9'd0};
		caps[6] = 9'($urandom_range(3, 40));
		caps[7] = 9'($urandom_range(0, 511));
		for (int p = 0; p < 8; p++) begin
			idle_on = (p % 2) == 0;
			set_capacity(caps[p]);
			run_mixed_phase(140, (p % 3 == 0) ? 65 : 55);
		end
	endtask

	task automatic test_calm_tail();
		idle_on = 1'b0;
		set_capacity(9'($urandom_range(4, 48)));
		run_mixed_phase(100, 55);
	endtask

	task automatic check_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch expected %h actual %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// receiver stalls
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold    <= ready_hold - 1;
			m_axis_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			ready_hold    <= $urandom_range(1, 17) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// result checking and watchdog
	always @(posedge clk) begin
		stack_result_t want;
		if (m_axis_tvalid && m_axis_tready && arst_n) begin
			if (results_due.size() == 0) begin
				$display("%0t: result beat with nothing expected, actual %h", $time, m_axis_tdata);
				mismatches++;
			end else begin
				want = results_due.pop_front();
				check_field("ok", DATA_W'(want.ok), DATA_W'(m_axis_tdata[0]));
				check_field("read_data", want.read_data, m_axis_tdata[32:1]);
				check_field("count_a", DATA_W'(want.count_a), DATA_W'(m_axis_tdata[41:33]));
				check_field("count_b", DATA_W'(want.count_b), DATA_W'(m_axis_tdata[50:42]));
				check_field("full_res", DATA_W'(want.full), DATA_W'(m_axis_tdata[51]));
				beats_checked++;
				if (want.full)
					full_seen++;
				if (!want.ok)
					rejected_seen++;
			end
		end
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= STALL_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
			$display("FAIL dual_stack_shared_array_core");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		capacity_words = DEPTH_DEF;
		level_a = 0;
		level_b = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_capacity_edges();
		test_fill_full();
		test_random_mix();
		test_calm_tail();
		wait_results_drained();
		repeat (8) @(posedge clk);
		$display("sent %0d command beats over %0d capacity writes; checked %0d results",
			beats_sent, capacity_writes, beats_checked);
		$display("results with full flag: %0d, rejected commands: %0d", full_seen, rejected_seen);
		if (mismatches == 0)
			$display("PASS dual_stack_shared_array_core");
		else
			$display("FAIL dual_stack_shared_array_core");
		$finish;
	end

endmodule
